[src/assert_macros.svh]
// Assertion macros shared by the integrator RTL.
// Users must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define AB4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define AB4_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/ab4_pkg.sv]
// Shared constants, types and helpers of the Adams-Bashforth point integrator.
// No dependencies.
package ab4_pkg;

  localparam int unsigned NUM_POINTS = 4096;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned ADDR_W     = $clog2(NUM_POINTS);
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned LANES      = 3;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned GAIN_W     = 18;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_GAIN = 1'b1;
  localparam logic [STEP_W-1:0]    STEP_RESET       = '0;
  localparam logic [GAIN_W-1:0]    GAIN_RESET       = GAIN_W'(65536);

  // Weighted rate sum: 55 r - 59 h1 + 37 h2 - 9 h3
  localparam int unsigned SUM_W  = VAL_W + 8;
  localparam int unsigned SMAG_W = SUM_W - 1;
  localparam logic signed [SUM_W-1:0] AB_C0 = SUM_W'(55);
  localparam logic signed [SUM_W-1:0] AB_C1 = SUM_W'(59);
  localparam logic signed [SUM_W-1:0] AB_C2 = SUM_W'(37);
  localparam logic signed [SUM_W-1:0] AB_C3 = SUM_W'(9);

  // |S| * gain, then * dt as two partial products
  localparam int unsigned PROD1_W  = SMAG_W + GAIN_W;
  localparam int unsigned PLO_W    = 32;
  localparam int unsigned PHI_W    = PROD1_W - PLO_W;
  localparam int unsigned PPLO_W   = PLO_W + STEP_W;
  localparam int unsigned PPHI_W   = PHI_W + STEP_W;

  // Rounding: add half of 24 * 2^48, keep bits from 2^48 upwards
  localparam int unsigned RND_W     = PROD1_W + STEP_W + 1;
  localparam int unsigned RND_SHIFT = 48;
  localparam logic [RND_W-1:0] RND_BIAS = RND_W'(12) << RND_SHIFT;
  localparam int unsigned A_W       = RND_W - RND_SHIFT;

  // Divide by 24 = 8 * 3; the /3 is a reciprocal multiply, exact for X_W bits
  localparam int unsigned DIV_PRE   = 3;
  localparam int unsigned X_W       = A_W - DIV_PRE;
  localparam int unsigned XL_W      = (X_W + 1) / 2;
  localparam int unsigned XH_W      = X_W - XL_W;
  localparam int unsigned RECIP_SH  = X_W + 1;
  localparam int unsigned RECIP_W   = RECIP_SH - 1;
  localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(((64'd1 << RECIP_SH) + 64'd2) / 64'd3);
  localparam int unsigned DLO_W     = XL_W + RECIP_W;
  localparam int unsigned DHI_W     = XH_W + RECIP_W;
  localparam int unsigned QP_W      = X_W + RECIP_W;
  localparam int unsigned MAG_W     = QP_W - RECIP_SH;

  localparam int unsigned RES_W     = MAG_W + 2;
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic [LANES-1:0][VAL_W-1:0] vec3_t;

  // One history entry: the three previous rates of a point
  typedef struct packed {
    vec3_t h3;
    vec3_t h2;
    vec3_t h1;
  } hist_t;

  function automatic logic pt_in_range(input logic [IDX_W-1:0] idx);
    pt_in_range = {1'b0, idx} < (IDX_W+1)'(NUM_POINTS);
  endfunction

endpackage

[src/ab4_if.sv]
// Channel interfaces of the integrator: point items, results and configuration.
// Depends on ab4_pkg.
interface ab4_pt_in_if import ab4_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        point_index;
  logic                    active;
  logic signed [VAL_W-1:0] pos_x_in;
  logic signed [VAL_W-1:0] pos_y_in;
  logic signed [VAL_W-1:0] pos_z_in;
  logic signed [VAL_W-1:0] rate_x;
  logic signed [VAL_W-1:0] rate_y;
  logic signed [VAL_W-1:0] rate_z;

  modport source (output valid, point_index, active, pos_x_in, pos_y_in, pos_z_in,
                  rate_x, rate_y, rate_z, input ready);
  modport sink   (input valid, point_index, active, pos_x_in, pos_y_in, pos_z_in,
                  rate_x, rate_y, rate_z, output ready);
endinterface

interface ab4_pt_out_if import ab4_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] pos_x_out;
  logic signed [VAL_W-1:0] pos_y_out;
  logic signed [VAL_W-1:0] pos_z_out;
  logic                    saturated;

  modport source (output valid, pos_x_out, pos_y_out, pos_z_out, saturated, input ready);
  modport sink   (input valid, pos_x_out, pos_y_out, pos_z_out, saturated, output ready);
endinterface

interface ab4_cfg_if import ab4_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/ab4_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ab4_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/adams_bashforth4_point_integrator_unit.sv]
// One item per cycle while the output is taken and no history clear is running.
// Throughput is set by the history RAM: one read and one write-back per cycle,
// with same-point repeats forwarded from the write-back stage.
// Reset clears the registers (dt = 0, gain = 1.0) and then sweeps all NUM_POINTS
// (4096) history RAM entries with input ready low; configuration writes are taken.
// Depends on ab4_pkg, ab4_if, ab4_ram and assert_macros.svh.
`include "assert_macros.svh"

module adams_bashforth4_point_integrator_unit import ab4_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  ab4_cfg_if.sink      cfg_i,
  ab4_pt_in_if.sink    pt_in_i,
  ab4_pt_out_if.source pt_out_o
);

  localparam int unsigned NSTG = 8;

  typedef struct packed {
    logic  act;
    vec3_t pos;
  } pass_t;

  // Configuration
  logic [STEP_W-1:0] step_q;
  logic [GAIN_W-1:0] gain_q;

  // Control
  logic              adv;
  logic              in_acc;
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic [NSTG:1]     vld_q;
  pass_t             pass_q [NSTG:1];
  logic [LANES-1:0]  neg_q [NSTG:3];

  // Write-back stage
  logic [IDX_W-1:0]  p1_idx_q;
  vec3_t             p1_rate_q;
  logic              p1_hit_q;
  hist_t             p1_fwd_q;
  logic              hit_d;
  hist_t             cur;
  hist_t             wb_data;

  // History RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  hist_t             ram_wdata;
  hist_t             ram_rdata;

  // Datapath, one entry per lane
  logic signed [SUM_W-1:0] sum_q   [LANES];
  logic signed [SUM_W-1:0] sum_d   [LANES];
  logic [SMAG_W-1:0]       smag_q  [LANES];
  logic [SMAG_W-1:0]       smag_d  [LANES];
  logic [LANES-1:0]        neg_d;
  logic [PROD1_W-1:0]      tprod_q [LANES];
  logic [PROD1_W-1:0]      tprod_d [LANES];
  logic [PPLO_W-1:0]       pplo_q  [LANES];
  logic [PPLO_W-1:0]       pplo_d  [LANES];
  logic [PPHI_W-1:0]       pphi_q  [LANES];
  logic [PPHI_W-1:0]       pphi_d  [LANES];
  logic [A_W-1:0]          a_q     [LANES];
  logic [A_W-1:0]          a_d     [LANES];
  logic [DLO_W-1:0]        dlo_q   [LANES];
  logic [DLO_W-1:0]        dlo_d   [LANES];
  logic [DHI_W-1:0]        dhi_q   [LANES];
  logic [DHI_W-1:0]        dhi_d   [LANES];
  logic [MAG_W-1:0]        mag_q   [LANES];
  logic [MAG_W-1:0]        mag_d   [LANES];

  // Output register
  logic              out_vld_q;
  vec3_t             out_pos_q;
  vec3_t             out_pos_d;
  logic              out_sat_q;
  logic              out_sat_d;

  // Whole pipeline moves together; the output register frees a slot when taken
  assign adv    = !out_vld_q || pt_out_o.ready;
  assign in_acc = pt_in_i.valid && pt_in_i.ready;

  assign pt_in_i.ready = adv && !clr_busy_q;
  assign cfg_i.ready   = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
      gain_q <= GAIN_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_STEP_SIZE:    step_q <= cfg_i.data[STEP_W-1:0];
        CFG_DAMPING_GAIN: gain_q <= cfg_i.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // History clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(NUM_POINTS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // History RAM: read on transfer, write back one stage later
  assign ram_we    = clr_busy_q || (adv && vld_q[1] && pass_q[1].act);
  assign ram_waddr = clr_busy_q ? clr_addr_q : p1_idx_q[ADDR_W-1:0];
  assign ram_wdata = clr_busy_q ? '0 : wb_data;

  ab4_ram #(
    .Width ($bits(hist_t)),
    .Depth (NUM_POINTS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (adv),
    .raddr_i (pt_in_i.point_index[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // The read of a point whose previous item writes back in the same cycle sees
  // stale data, so take the write-back value instead.
  assign hit_d = vld_q[1] && pass_q[1].act && (p1_idx_q == pt_in_i.point_index);

  always_comb begin
    cur         = p1_hit_q ? p1_fwd_q : ram_rdata;
    wb_data.h3  = cur.h2;
    wb_data.h2  = cur.h1;
    wb_data.h1  = p1_rate_q;
  end

  // ---------------------------------------------------------------------------
  // Valid bits and pass-through fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NSTG-1:1], in_acc};
      out_vld_q <= vld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pass_q[1].act <= pt_in_i.active && pt_in_range(pt_in_i.point_index);
      pass_q[1].pos <= {pt_in_i.pos_z_in, pt_in_i.pos_y_in, pt_in_i.pos_x_in};
      p1_rate_q     <= {pt_in_i.rate_z, pt_in_i.rate_y, pt_in_i.rate_x};
      p1_idx_q      <= pt_in_i.point_index;
      p1_hit_q      <= hit_d;
      p1_fwd_q      <= wb_data;
      for (int s = 2; s <= NSTG; s++) begin
        pass_q[s] <= pass_q[s-1];
      end
      neg_q[3] <= neg_d;
      for (int s = 4; s <= NSTG; s++) begin
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic stages
  always_comb begin
    logic [RND_W-1:0]        rnd;
    logic [X_W-1:0]          x;
    logic [QP_W-1:0]         qp;
    logic signed [RES_W-1:0] pos_e;
    logic signed [RES_W-1:0] mag_e;
    logic signed [RES_W-1:0] res;
    logic                    ovf;
    logic [LANES-1:0]        lane_sat;

    lane_sat = '0;
    for (int k = 0; k < LANES; k++) begin
      // S1: weighted sum of new rate and history
      sum_d[k] = AB_C0 * SUM_W'($signed(p1_rate_q[k]))
               - AB_C1 * SUM_W'($signed(cur.h1[k]))
               + AB_C2 * SUM_W'($signed(cur.h2[k]))
               - AB_C3 * SUM_W'($signed(cur.h3[k]));

      // S2: sign and magnitude
      neg_d[k]  = sum_q[k][SUM_W-1];
      smag_d[k] = neg_d[k] ? SMAG_W'(-sum_q[k]) : SMAG_W'(sum_q[k]);

      // S3: times damping gain
      tprod_d[k] = PROD1_W'(smag_q[k]) * PROD1_W'(gain_q);

      // S4: times dt, split in low and high partial products
      pplo_d[k] = PPLO_W'(tprod_q[k][PLO_W-1:0]) * PPLO_W'(step_q);
      pphi_d[k] = PPHI_W'(tprod_q[k][PROD1_W-1:PLO_W]) * PPHI_W'(step_q);

      // S5: combine, bias for round half away from zero, drop 48 fraction bits
      rnd    = RND_W'(pplo_q[k]) + (RND_W'(pphi_q[k]) << PLO_W) + RND_BIAS;
      a_d[k] = rnd[RND_W-1:RND_SHIFT];

      // S6: /8 by shift, /3 by reciprocal in two partial products
      x        = a_q[k][A_W-1:DIV_PRE];
      dlo_d[k] = DLO_W'(x[XL_W-1:0]) * DLO_W'(RECIP3);
      dhi_d[k] = DHI_W'(x[X_W-1:XL_W]) * DHI_W'(RECIP3);

      // S7: quotient
      qp       = QP_W'(dlo_q[k]) + (QP_W'(dhi_q[k]) << XL_W);
      mag_d[k] = qp[QP_W-1:RECIP_SH];

      // S8: apply increment and clamp
      pos_e = RES_W'($signed(pass_q[NSTG].pos[k]));
      mag_e = $signed(RES_W'(mag_q[k]));
      res   = neg_q[NSTG][k] ? pos_e - mag_e : pos_e + mag_e;
      ovf   = (res[RES_W-1:VAL_W-1] != '0) && (res[RES_W-1:VAL_W-1] != '1);
      if (!pass_q[NSTG].act) begin
        out_pos_d[k] = pass_q[NSTG].pos[k];
      end else if (ovf) begin
        out_pos_d[k] = res[RES_W-1] ? VAL_MIN : VAL_MAX;
        lane_sat[k]  = 1'b1;
      end else begin
        out_pos_d[k] = res[VAL_W-1:0];
      end
    end
    out_sat_d = |lane_sat;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < LANES; k++) begin
        sum_q[k]   <= sum_d[k];
        smag_q[k]  <= smag_d[k];
        tprod_q[k] <= tprod_d[k];
        pplo_q[k]  <= pplo_d[k];
        pphi_q[k]  <= pphi_d[k];
        a_q[k]     <= a_d[k];
        dlo_q[k]   <= dlo_d[k];
        dhi_q[k]   <= dhi_d[k];
        mag_q[k]   <= mag_d[k];
      end
      out_pos_q <= out_pos_d;
      out_sat_q <= out_sat_d;
    end
  end

  assign pt_out_o.valid     = out_vld_q;
  assign pt_out_o.pos_x_out = out_pos_q[0];
  assign pt_out_o.pos_y_out = out_pos_q[1];
  assign pt_out_o.pos_z_out = out_pos_q[2];
  assign pt_out_o.saturated = out_sat_q;

  // ---------------------------------------------------------------------------
  `AB4_ASSERT_ALWAYS(a_empty_while_clearing, clr_busy_q |-> !(|vld_q), "item in pipe during clear")
  `AB4_ASSERT(a_clear_once, !clr_busy_q |=> !clr_busy_q, "history clear restarted")
  `AB4_ASSERT(a_no_wb_on_stall, !adv && !clr_busy_q |-> !ram_we, "history written while stalled")
  `AB4_ASSERT(a_inactive_passes, adv && vld_q[NSTG] && !pass_q[NSTG].act |=> out_pos_q == $past(pass_q[NSTG].pos) && !out_sat_q, "inactive point altered")
  `AB4_ASSERT(a_sat_at_bound, out_vld_q && out_sat_q |-> out_pos_q[0] == VAL_MAX || out_pos_q[0] == VAL_MIN || out_pos_q[1] == VAL_MAX || out_pos_q[1] == VAL_MIN || out_pos_q[2] == VAL_MAX || out_pos_q[2] == VAL_MIN, "saturation flag without clamped lane")

endmodule
